FILE: rtl/mafs_pkg.sv
`default_nettype none

package mafs_pkg;

	// stream position counter width
	localparam int POSITION_BITS = 32;

	// frame length divider: quotient bits, one per step
	localparam int DIV_STEPS = 12;
	localparam int CNT_BITS  = $clog2(DIV_STEPS);
	localparam int COEF_BITS = 18;
	localparam int RATE_BITS = 9;
	localparam int FREQ_BITS = 16;
	localparam int PROD_BITS = COEF_BITS + RATE_BITS;
	localparam int LEN_BITS  = 11;
	localparam int LEN_MAX   = (1 << LEN_BITS) - 1;

	// version codes as reported
	localparam logic [1:0] VER_MPEG1  = 2'd0;
	localparam logic [1:0] VER_MPEG2  = 2'd1;
	localparam logic [1:0] VER_MPEG25 = 2'd2;

	// layer numbers
	localparam logic [1:0] LAYER_NONE = 2'd0;
	localparam logic [1:0] LAYER_1    = 2'd1;
	localparam logic [1:0] LAYER_2    = 2'd2;
	localparam logic [1:0] LAYER_3    = 2'd3;

	// channel mode code for single channel
	localparam logic [1:0] MODE_MONO = 2'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_LOAD
	} state_t;

	// controller to datapath commands
	typedef struct packed {
		logic shift;
		logic capture;
		logic mul;
		logic div_step;
		logic load;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic hdr_ok;
	} sts_t;

	// bitrate tables in kbit/s
	localparam logic [RATE_BITS-1:0] RATE_V1_L1 [16] = '{
		9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
		9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0};
	localparam logic [RATE_BITS-1:0] RATE_V1_L2 [16] = '{
		9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
		9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0};
	localparam logic [RATE_BITS-1:0] RATE_V1_L3 [16] = '{
		9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
		9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0};
	localparam logic [RATE_BITS-1:0] RATE_V2_L1 [16] = '{
		9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
		9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0};
	localparam logic [RATE_BITS-1:0] RATE_V2_L23 [16] = '{
		9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
		9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0};

	// sample rates in hz, reserved index reads zero
	localparam logic [FREQ_BITS-1:0] FREQ_V1 [4]  = '{16'd44100, 16'd48000, 16'd32000, 16'd0};
	localparam logic [FREQ_BITS-1:0] FREQ_V2 [4]  = '{16'd22050, 16'd24000, 16'd16000, 16'd0};
	localparam logic [FREQ_BITS-1:0] FREQ_V25 [4] = '{16'd11025, 16'd12000, 16'd8000, 16'd0};

	function automatic logic [RATE_BITS-1:0] rate_lookup(input logic [1:0] ver,
		input logic [1:0] layer, input logic [3:0] idx);
		logic [RATE_BITS-1:0] r;
		r = '0;
		if (ver == VER_MPEG1) begin
			case (layer)
				LAYER_1: r = RATE_V1_L1[idx];
				LAYER_2: r = RATE_V1_L2[idx];
				LAYER_3: r = RATE_V1_L3[idx];
				default: r = '0;
			endcase
		end else begin
			case (layer)
				LAYER_1: r = RATE_V2_L1[idx];
				LAYER_2, LAYER_3: r = RATE_V2_L23[idx];
				default: r = '0;
			endcase
		end
		return r;
	endfunction

	function automatic logic [FREQ_BITS-1:0] freq_lookup(input logic [1:0] ver,
		input logic [1:0] idx);
		logic [FREQ_BITS-1:0] f;
		case (ver)
			VER_MPEG1:  f = FREQ_V1[idx];
			VER_MPEG2:  f = FREQ_V2[idx];
			VER_MPEG25: f = FREQ_V25[idx];
			default:    f = '0;
		endcase
		return f;
	endfunction

	function automatic logic [10:0] spf_lookup(input logic [1:0] ver, input logic [1:0] layer);
		logic [10:0] s;
		case (layer)
			LAYER_1: s = 11'd384;
			LAYER_2: s = 11'd1152;
			LAYER_3: s = (ver == VER_MPEG1) ? 11'd1152 : 11'd576;
			default: s = 11'd0;
		endcase
		return s;
	endfunction

	// length numerator factor: 12000 for layer i, spf/8*1000 otherwise
	function automatic logic [COEF_BITS-1:0] coef_lookup(input logic [1:0] layer,
		input logic [10:0] spf);
		logic [COEF_BITS-1:0] c;
		if (layer == LAYER_1) begin
			c = 18'd12000;
		end else if (spf == 11'd1152) begin
			c = 18'd144000;
		end else begin
			c = 18'd72000;
		end
		return c;
	endfunction

	// allowed layer ii bitrate and mode pairs
	function automatic logic layer2_ok(input logic [RATE_BITS-1:0] rate, input logic mono);
		logic ok;
		ok = 1'b0;
		if (rate inside {9'd64, 9'd96, 9'd112, 9'd128, 9'd160, 9'd192}) begin
			ok = 1'b1;
		end else if (!mono && (rate inside {9'd224, 9'd256, 9'd320, 9'd384})) begin
			ok = 1'b1;
		end else if (mono && (rate inside {9'd32, 9'd48, 9'd56, 9'd80})) begin
			ok = 1'b1;
		end
		return ok;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/mpeg_audio_frame_sync_finder_core.sv
`default_nettype none

// MPEG audio frame sync finder. Takes the stream one byte per request and
// tests every four-byte window as a frame header; a passing header yields one
// result with its stream offset and decoded frame parameters. Bytes that do not
// complete a valid header are taken one per cycle while no frame length is
// being formed. A byte that completes a valid header holds the input while the
// frame length is formed (a multiply step, then a restoring divider that forms
// the 12-bit quotient one bit per cycle, then the load into the result
// register), and longer if the previous result is still stalled at the output.
// Byte traffic keeps flowing while a finished result waits to be taken. The
// first three bytes after reset only fill the window. The offset counter wraps at 32 bits.
module mpeg_audio_frame_sync_finder_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  data_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      header_offset,
	output logic [10:0]      frame_bytes,
	output logic [8:0]       bitrate_kbps,
	output logic [15:0]      sample_rate_hz,
	output logic [1:0]       layer_number,
	output logic [1:0]       version_code,
	output logic [1:0]       channel_count,
	output logic [10:0]      samples_per_frame,
	output logic             crc_present,
	output logic             padding_flag
);

	mafs_pkg::cmd_t cmd;
	mafs_pkg::sts_t sts;

	// sequencing and handshakes
	mafs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// window, decode, divider and result register
	mafs_dp u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.data_byte         (data_byte),
		.header_offset     (header_offset),
		.frame_bytes       (frame_bytes),
		.bitrate_kbps      (bitrate_kbps),
		.sample_rate_hz    (sample_rate_hz),
		.layer_number      (layer_number),
		.version_code      (version_code),
		.channel_count     (channel_count),
		.samples_per_frame (samples_per_frame),
		.crc_present       (crc_present),
		.padding_flag      (padding_flag)
	);

endmodule

`default_nettype wire

FILE: rtl/mafs_ctrl.sv
`default_nettype none

module mafs_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_stall,
	output logic                 out_valid,
	input  wire logic            out_stall,
	input  wire mafs_pkg::sts_t  sts,
	output mafs_pkg::cmd_t       cmd
);

	mafs_pkg::state_t                 state_q, state_d;
	logic [mafs_pkg::CNT_BITS-1:0]    cnt_q, cnt_d;
	logic                             out_valid_q;
	logic                             in_take;
	logic                             out_take;

	assign out_valid = out_valid_q;
	assign out_take  = out_valid_q && !out_stall;

	// state and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mafs_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		cmd      = '0;
		in_stall = 1'b1;
		in_take  = 1'b0;
		case (state_q)
			mafs_pkg::ST_IDLE: begin
				in_stall    = 1'b0;
				in_take     = in_valid;
				cmd.shift   = in_take;
				cmd.capture = in_take && sts.hdr_ok;
				if (cmd.capture) begin
					state_d = mafs_pkg::ST_MUL;
				end
			end
			mafs_pkg::ST_MUL: begin
				cmd.mul = 1'b1;
				cnt_d   = '0;
				state_d = mafs_pkg::ST_DIV;
			end
			mafs_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q + 1'b1;
				if (cnt_q == mafs_pkg::CNT_BITS'(mafs_pkg::DIV_STEPS - 1)) begin
					state_d = mafs_pkg::ST_LOAD;
				end
			end
			mafs_pkg::ST_LOAD: begin
				if (!out_valid_q || !out_stall) begin
					cmd.load = 1'b1;
					state_d  = mafs_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = mafs_pkg::ST_IDLE;
			end
		endcase
	end

	// result register occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

`ifndef ASSERT_OFF
	// a new result never overwrites one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> (!out_valid_q || !out_stall))
		else $error("result overwritten while stalled");

	// a passing header always starts the length computation
	a_capture_starts: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> (state_q == mafs_pkg::ST_MUL))
		else $error("capture did not start computation");

	// a stalled result stays offered
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> out_valid_q)
		else $error("stalled result dropped");

	// divider step count stays in range
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mafs_pkg::ST_DIV) |->
		(cnt_q <= mafs_pkg::CNT_BITS'(mafs_pkg::DIV_STEPS - 1)))
		else $error("divider step count out of range");
`endif

endmodule

`default_nettype wire

FILE: rtl/mafs_dp.sv
`default_nettype none

module mafs_dp (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire mafs_pkg::cmd_t  cmd,
	output mafs_pkg::sts_t       sts,
	input  wire logic [7:0]      data_byte,
	output logic [31:0]          header_offset,
	output logic [10:0]          frame_bytes,
	output logic [8:0]           bitrate_kbps,
	output logic [15:0]          sample_rate_hz,
	output logic [1:0]           layer_number,
	output logic [1:0]           version_code,
	output logic [1:0]           channel_count,
	output logic [10:0]          samples_per_frame,
	output logic                 crc_present,
	output logic                 padding_flag
);

	localparam int PB = mafs_pkg::POSITION_BITS;
	localparam int PW = mafs_pkg::PROD_BITS;
	localparam int QB = mafs_pkg::DIV_STEPS;

	// window, fill count and position
	logic [7:0]    win_q [3];
	logic [1:0]    seen_q;
	logic [PB-1:0] pos_q;

	// decode of the current window
	logic [7:0]                        b0, b1, b2, b3;
	logic [1:0]                        vbits, lbits, ver, layer, mode;
	logic [mafs_pkg::RATE_BITS-1:0]    rate;
	logic [mafs_pkg::FREQ_BITS-1:0]    freq;
	logic [10:0]                       spf;
	logic                              full;
	logic [PB-1:0]                     offset;

	// captured header
	logic [mafs_pkg::RATE_BITS-1:0]    rate_q;
	logic [mafs_pkg::FREQ_BITS-1:0]    freq_q;
	logic [mafs_pkg::COEF_BITS-1:0]    coef_q;
	logic [1:0]                        layer_q, ver_q;
	logic                              mono_q, crc_q, pad_q;
	logic [10:0]                       spf_q;
	logic [PB-1:0]                     off_q;

	// divider
	logic [PW-1:0] rem_q, div_q;
	logic [QB-1:0] quot_q;

	// length assembly
	logic [QB:0]   qp;
	logic [QB+2:0] len_full;
	logic [63:0]   off_ext;

	assign b0 = win_q[0];
	assign b1 = win_q[1];
	assign b2 = win_q[2];
	assign b3 = data_byte;

	// header field decode
	always_comb begin
		vbits = b1[4:3];
		lbits = b1[2:1];
		mode  = b3[7:6];
		full  = (seen_q == 2'd3);
		case (vbits)
			2'd0:    ver = mafs_pkg::VER_MPEG25;
			2'd2:    ver = mafs_pkg::VER_MPEG2;
			default: ver = mafs_pkg::VER_MPEG1;
		endcase
		case (lbits)
			2'd1:    layer = mafs_pkg::LAYER_3;
			2'd2:    layer = mafs_pkg::LAYER_2;
			2'd3:    layer = mafs_pkg::LAYER_1;
			default: layer = mafs_pkg::LAYER_NONE;
		endcase
		rate = mafs_pkg::rate_lookup(ver, layer, b2[7:4]);
		freq = mafs_pkg::freq_lookup(ver, b2[3:2]);
		spf  = mafs_pkg::spf_lookup(ver, layer);
		sts.hdr_ok = full && (b0 == 8'hFF) && (layer != mafs_pkg::LAYER_NONE)
			&& (rate != '0) && (freq != '0)
			&& ((layer != mafs_pkg::LAYER_2)
			|| mafs_pkg::layer2_ok(rate, mode == mafs_pkg::MODE_MONO));
		offset = pos_q - PB'(3);
	end

	// byte window shift
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q[0] <= '0;
			win_q[1] <= '0;
			win_q[2] <= '0;
			seen_q   <= '0;
			pos_q    <= '0;
		end else if (cmd.shift) begin
			win_q[0] <= win_q[1];
			win_q[1] <= win_q[2];
			win_q[2] <= data_byte;
			if (seen_q != 2'd3) begin
				seen_q <= seen_q + 2'd1;
			end
			pos_q <= pos_q + PB'(1);
		end
	end

	// header capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			rate_q  <= rate;
			freq_q  <= freq;
			coef_q  <= mafs_pkg::coef_lookup(layer, spf);
			layer_q <= layer;
			ver_q   <= ver;
			mono_q  <= (mode == mafs_pkg::MODE_MONO);
			crc_q   <= !b1[0];
			pad_q   <= b2[1];
			spf_q   <= spf;
			off_q   <= offset;
		end
	end

	// numerator product, then restoring division one quotient bit per step
	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			rem_q  <= PW'(coef_q) * PW'(rate_q);
			div_q  <= {freq_q, (PW - mafs_pkg::FREQ_BITS)'(0)} >> (PW - mafs_pkg::FREQ_BITS - (QB - 1));
			quot_q <= '0;
		end else if (cmd.div_step) begin
			if (rem_q >= div_q) begin
				rem_q  <= rem_q - div_q;
				quot_q <= {quot_q[QB-2:0], 1'b1};
			end else begin
				quot_q <= {quot_q[QB-2:0], 1'b0};
			end
			div_q <= div_q >> 1;
		end
	end

	// frame length with padding, layer i counts four-byte slots
	always_comb begin
		qp = (QB + 1)'(quot_q) + (QB + 1)'(pad_q);
		if (layer_q == mafs_pkg::LAYER_1) begin
			len_full = {qp, 2'b00};
		end else begin
			len_full = (QB + 3)'(qp);
		end
		off_ext = 64'(off_q);
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			header_offset <= off_ext[31:0];
			if (len_full > (QB + 3)'(mafs_pkg::LEN_MAX)) begin
				frame_bytes <= mafs_pkg::LEN_BITS'(mafs_pkg::LEN_MAX);
			end else begin
				frame_bytes <= len_full[mafs_pkg::LEN_BITS-1:0];
			end
			bitrate_kbps      <= rate_q;
			sample_rate_hz    <= freq_q;
			layer_number      <= layer_q;
			version_code      <= ver_q;
			channel_count     <= mono_q ? 2'd1 : 2'd2;
			samples_per_frame <= spf_q;
			crc_present       <= crc_q;
			padding_flag      <= pad_q;
		end
	end

endmodule

`default_nettype wire

FILE: test/mpeg_audio_frame_sync_finder_core_tb.sv
`default_nettype none

module mpeg_audio_frame_sync_finder_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// decoded frame description, one per passing header
	typedef struct packed {
		logic [31:0] offset;
		logic [10:0] length;
		logic [8:0]  kbps;
		logic [15:0] hz;
		logic [1:0]  layer;
		logic [1:0]  version;
		logic [1:0]  chans;
		logic [10:0] spf;
		logic        crc;
		logic        pad;
	} frame_info_t;

	// bitrate rows in kbit/s
	localparam int unsigned KBPS_V1_L1 [16] = '{0, 32, 64, 96, 128, 160, 192, 224,
		256, 288, 320, 352, 384, 416, 448, 0};
	localparam int unsigned KBPS_V1_L2 [16] = '{0, 32, 48, 56, 64, 80, 96, 112,
		128, 160, 192, 224, 256, 320, 384, 0};
	localparam int unsigned KBPS_V1_L3 [16] = '{0, 32, 40, 48, 56, 64, 80, 96,
		112, 128, 160, 192, 224, 256, 320, 0};
	localparam int unsigned KBPS_LSF_L1 [16] = '{0, 32, 48, 56, 64, 80, 96, 112,
		128, 144, 160, 176, 192, 224, 256, 0};
	localparam int unsigned KBPS_LSF_L23 [16] = '{0, 8, 16, 24, 32, 40, 48, 56,
		64, 80, 96, 112, 128, 144, 160, 0};
	localparam int unsigned HZ_V1 [4]  = '{44100, 48000, 32000, 0};
	localparam int unsigned HZ_V2 [4]  = '{22050, 24000, 16000, 0};
	localparam int unsigned HZ_V25 [4] = '{11025, 12000, 8000, 0};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte = 8'h00;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] header_offset;
	logic [10:0] frame_bytes;
	logic [8:0]  bitrate_kbps;
	logic [15:0] sample_rate_hz;
	logic [1:0]  layer_number;
	logic [1:0]  version_code;
	logic [1:0]  channel_count;
	logic [10:0] samples_per_frame;
	logic        crc_present;
	logic        padding_flag;

	// predictor state: last three bytes, fill level, stream position
	logic [7:0]  hist [3];
	int          hist_fill;
	logic [31:0] stream_pos;

	frame_info_t expected_frames [$];
	int          mismatches = 0;
	bit          quiet_tail = 1'b0;
	int          stall_left = 0;
	int          calm_left = 0;

	mpeg_audio_frame_sync_finder_core DUT (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.data_byte         (data_byte),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.header_offset     (header_offset),
		.frame_bytes       (frame_bytes),
		.bitrate_kbps      (bitrate_kbps),
		.sample_rate_hz    (sample_rate_hz),
		.layer_number      (layer_number),
		.version_code      (version_code),
		.channel_count     (channel_count),
		.samples_per_frame (samples_per_frame),
		.crc_present       (crc_present),
		.padding_flag      (padding_flag)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// bitrate for version, layer and index
	function automatic int unsigned kbps_for(input logic [1:0] ver, input int layer,
		input logic [3:0] idx);
		if (ver == mafs_pkg::VER_MPEG1) begin
			case (layer)
				1: return KBPS_V1_L1[idx];
				2: return KBPS_V1_L2[idx];
				default: return KBPS_V1_L3[idx];
			endcase
		end
		if (layer == 1) begin
			return KBPS_LSF_L1[idx];
		end
		return KBPS_LSF_L23[idx];
	endfunction

	function automatic int unsigned hz_for(input logic [1:0] ver, input logic [1:0] idx);
		case (ver)
			mafs_pkg::VER_MPEG1: return HZ_V1[idx];
			mafs_pkg::VER_MPEG2: return HZ_V2[idx];
			default:             return HZ_V25[idx];
		endcase
	endfunction

	// layer ii rule on bitrate against mono or not
	function automatic bit layer2_pair_allowed(input int unsigned kbps, input bit mono);
		case (kbps)
			64, 96, 112, 128, 160, 192: return 1'b1;
			224, 256, 320, 384:         return !mono;
			32, 48, 56, 80:             return mono;
			default:                    return 1'b0;
		endcase
	endfunction

	// test one four-byte window as a header, fill in the frame when it passes
	function automatic bit decode_header(input logic [7:0] h0, h1, h2, h3,
		input logic [31:0] at, output frame_info_t f);
		logic [1:0]  ver;
		int          layer;
		int unsigned kbps;
		int unsigned hz;
		int unsigned spf;
		int unsigned len;
		bit          pad;
		bit          mono;
		f = '0;
		if (h0 != 8'hFF || h1[2:1] == 2'b00) begin
			return 1'b0;
		end
		case (h1[4:3])
			2'b00:   ver = mafs_pkg::VER_MPEG25;
			2'b10:   ver = mafs_pkg::VER_MPEG2;
			default: ver = mafs_pkg::VER_MPEG1;
		endcase
		layer = 4 - int'(h1[2:1]);
		kbps = kbps_for(ver, layer, h2[7:4]);
		hz = hz_for(ver, h2[3:2]);
		pad = h2[1];
		mono = (h3[7:6] == mafs_pkg::MODE_MONO);
		if (kbps == 0 || hz == 0 || (layer == 2 && !layer2_pair_allowed(kbps, mono))) begin
			return 1'b0;
		end
		if (layer == 1) begin
			spf = 384;
		end else if (layer == 2 || ver == mafs_pkg::VER_MPEG1) begin
			spf = 1152;
		end else begin
			spf = 576;
		end
		if (layer == 1) begin
			len = (12000 * kbps / hz + pad) * 4;
		end else begin
			len = (spf / 8) * 1000 * kbps / hz + pad;
		end
		if (len > 2047) begin
			len = 2047;
		end
		f.offset  = at - 32'd3;
		f.length  = len[10:0];
		f.kbps    = kbps[8:0];
		f.hz      = hz[15:0];
		f.layer   = layer[1:0];
		f.version = ver;
		f.chans   = mono ? 2'd1 : 2'd2;
		f.spf     = spf[10:0];
		f.crc     = !h1[0];
		f.pad     = pad;
		return 1'b1;
	endfunction

	// advance the predictor by one accepted byte
	task automatic take_byte(input logic [7:0] b);
		frame_info_t f;
		if (hist_fill == 3 && decode_header(hist[0], hist[1], hist[2], b, stream_pos, f)) begin
			expected_frames.push_back(f);
		end
		hist[0] = hist[1];
		hist[1] = hist[2];
		hist[2] = b;
		if (hist_fill < 3) begin
			hist_fill++;
		end
		stream_pos++;
	endtask

	// one byte request, with an occasional gap before it
	task automatic send_byte(input logic [7:0] b);
		if (!quiet_tail && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		take_byte(b);
	endtask

	task automatic send_header(input logic [7:0] h1, h2, h3);
		send_byte(8'hFF);
		send_byte(h1);
		send_byte(h2);
		send_byte(h3);
	endtask

	// drop valid and wait for every pending frame
	task automatic drain_frames();
		in_valid <= 1'b0;
		do @(posedge clk); while (expected_frames.size() != 0);
	endtask

	// header with sync bits set and random fields, sometimes a noisy second byte
	task automatic send_random_header();
		logic [7:0] h1;
		h1 = ($urandom_range(0, 7) == 0) ? 8'($urandom) : {3'b111, 5'($urandom)};
		send_header(h1, 8'($urandom), 8'($urandom));
		repeat ($urandom_range(0, 3)) send_byte(8'($urandom));
	endtask

	// known frames and rejections for a layer ii pair, a reserved layer and a bad bitrate index
	task automatic test_directed();
		send_header(8'hFB, 8'h90, 8'h64);
		send_header(8'hEB, 8'h90, 8'h00);
		send_header(8'hFE, 8'hE2, 8'hC0);
		send_header(8'hE5, 8'hE8, 8'h00);
		send_header(8'hFD, 8'h10, 8'h00);
		send_header(8'hF9, 8'h90, 8'h00);
		send_header(8'hFB, 8'hFC, 8'h00);
	endtask

	task automatic test_random_headers(input int count);
		repeat (count) send_random_header();
	endtask

	// sender holds off until the block has emptied
	task automatic test_pause_until_empty();
		repeat (6) send_random_header();
		drain_frames();
		repeat (6) send_random_header();
	endtask

	// random bytes with sync bytes common, runs of 0xff included
	task automatic test_noise(input int count);
		repeat (count) begin
			send_byte(($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom));
		end
	endtask

	// last stretch with no idling on either side
	task automatic test_no_idle(input int count);
		quiet_tail = 1'b1;
		repeat (count) send_random_header();
	endtask

	// result stall bursts, with calm stretches between
	initial begin
		forever begin
			@(posedge clk);
			if (stall_left == 0 && calm_left > 0) begin
				calm_left--;
			end else if (stall_left == 0 && !quiet_tail) begin
				if ($urandom_range(0, 19) == 0) begin
					calm_left = $urandom_range(20, 60);
				end else if ($urandom_range(0, 3) == 0) begin
					stall_left = $urandom_range(1, 6);
				end
			end
			if (stall_left > 0 && !quiet_tail) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
				stall_left = 0;
			end
		end
	end

	task automatic check_field(input string name, input logic [31:0] want, got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	// compare each taken result with the oldest pending frame
	always @(posedge clk) begin : check_results
		frame_info_t want;
		if (arst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
			if (expected_frames.size() == 0) begin
				$error("result at offset %0d with no frame pending", header_offset);
				mismatches++;
			end else begin
				want = expected_frames.pop_front();
				check_field("header_offset", want.offset, header_offset);
				check_field("frame_bytes", 32'(want.length), 32'(frame_bytes));
				check_field("bitrate_kbps", 32'(want.kbps), 32'(bitrate_kbps));
				check_field("sample_rate_hz", 32'(want.hz), 32'(sample_rate_hz));
				check_field("layer_number", 32'(want.layer), 32'(layer_number));
				check_field("version_code", 32'(want.version), 32'(version_code));
				check_field("channel_count", 32'(want.chans), 32'(channel_count));
				check_field("samples_per_frame", 32'(want.spf), 32'(samples_per_frame));
				check_field("crc_present", 32'(want.crc), 32'(crc_present));
				check_field("padding_flag", 32'(want.pad), 32'(padding_flag));
			end
		end
	end

	initial begin
		#2_000_000;
		$display("mpeg_audio_frame_sync_finder_core_tb: errors");
		$finish;
	end

	initial begin
		hist[0] = 8'h00;
		hist[1] = 8'h00;
		hist[2] = 8'h00;
		hist_fill = 0;
		stream_pos = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_random_headers(100);
		test_pause_until_empty();
		test_noise(80);
		test_no_idle(12);

		drain_frames();
		repeat (20) @(posedge clk);
		if (expected_frames.size() != 0) begin
			$error("%0d frames never reported", expected_frames.size());
			mismatches++;
		end
		if (mismatches == 0) begin
			$display("mpeg_audio_frame_sync_finder_core_tb: clean");
		end else begin
			$display("mpeg_audio_frame_sync_finder_core_tb: errors");
		end
		$finish;
	end

endmodule

`default_nettype wire
